// ----- sv/pemm_pkg.sv -----
// ---------------------------------------------------------------------------
// pemm_pkg
// Shared types and constants for the peak envelope min/max store: word
// layouts of the sample/query channel, the result channel and the register
// indexes of the configuration port.
// ---------------------------------------------------------------------------
package pemm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int BIN_BITS    = 12;
  localparam int SPB_BITS    = 16;
  localparam int NBINS_BITS  = 13;
  localparam int CFG_BITS    = 16;

  localparam logic [SPB_BITS-1:0]   SPB_RESET   = 16'd1;
  localparam logic [NBINS_BITS-1:0] NBINS_RESET = 13'd4096;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  typedef enum logic {
    CFG_SAMPLES_PER_BIN = 1'b0,
    CFG_BINS_IN_USE     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [BIN_BITS-1:0]     first_bin;
    logic [BIN_BITS-1:0]     last_bin;
  } in_word_t;

  typedef struct packed {
    kind_t                   result_kind;
    logic [BIN_BITS-1:0]     bin_number;
    logic signed [SAMPLE_BITS-1:0] low_value;
    logic signed [SAMPLE_BITS-1:0] high_value;
    logic signed [SAMPLE_BITS-1:0] overall_low;
    logic [SAMPLE_BITS-2:0]  overall_high;
    logic                    complete;
  } out_word_t;

endpackage

// ----- sv/pemm_env_ram.sv -----
// ---------------------------------------------------------------------------
// pemm_env_ram
// Envelope store: one entry per bin holding {bin minimum, bin maximum}.
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pemm_env_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/peak_envelope_min_max_store_top.sv -----
// ---------------------------------------------------------------------------
// peak_envelope_min_max_store_top
// Samples: a sample is folded in the cycle it is accepted; a bin report is
//   registered and valid on the next cycle. One sample per cycle unless a
//   query runs or the sink stalls. Query over N bins: N store reads (one bin
//   per cycle, read port bound), then a fold in S_QFOLD registers the result;
//   an empty range answers on the next cycle. One query at a time.
// Reset: registers to defaults, counters and running values zero. Bins not
//   yet written read as zero by the fill count, so no clearing pass runs.
// ---------------------------------------------------------------------------
module peak_envelope_min_max_store_top #(
  parameter int MAX_BINS = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pemm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pemm_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  pemm_pkg::cfg_idx_t                  cfg_index,
  input  logic [pemm_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int SB = pemm_pkg::SAMPLE_BITS;
  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int EW = (CW > pemm_pkg::NBINS_BITS) ? CW : pemm_pkg::NBINS_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRUN,
    S_QFOLD
  } state_t;

  state_t state;

  logic [pemm_pkg::SPB_BITS-1:0]   samples_per_bin;
  logic [pemm_pkg::NBINS_BITS-1:0] bins_in_use;

  logic [pemm_pkg::SPB_BITS-1:0] samples_in_bin;
  logic signed [SB-1:0]          current_low;
  logic signed [SB-1:0]          current_high;
  logic [CW-1:0]                 next_bin;
  logic signed [SB-1:0]          running_low;
  logic signed [SB-1:0]          running_high;
  logic                          filled;

  // query walk
  logic [AW-1:0]        k;
  logic [AW-1:0]        kend;
  logic                 pend;
  logic                 pend_written;
  logic signed [SB-1:0] acc_low;
  logic signed [SB-1:0] acc_high;

  logic [2*SB-1:0] rd_data;
  logic            wr_en;
  logic            out_load;

  logic                          accept;
  logic [EW-1:0]                 bins_e;
  logic [EW-1:0]                 nb;
  logic [EW-1:0]                 nb_m1;
  logic [EW-1:0]                 last_e;
  logic [EW-1:0]                 last_c;
  logic                          q_empty;
  logic                          over_end;
  logic [pemm_pkg::SPB_BITS-1:0] spb_eff;
  logic [pemm_pkg::SPB_BITS:0]   sib_inc;
  logic                          bin_done;
  logic signed [SB-1:0]          v;
  logic signed [SB-1:0]          low_next;
  logic signed [SB-1:0]          high_next;
  logic signed [SB-1:0]          run_low_next;
  logic signed [SB-1:0]          run_high_next;
  logic [CW-1:0]                 next_bin_inc;
  logic signed [SB-1:0]          rd_low;
  logic signed [SB-1:0]          rd_high;
  logic signed [SB-1:0]          f_low;
  logic signed [SB-1:0]          f_high;
  logic signed [SB-1:0]          acc_low_f;
  logic signed [SB-1:0]          acc_high_f;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept    = in_valid && in_ready;

  always_comb begin
    bins_e = EW'(bins_in_use);
    if (bins_e == '0) begin
      nb = EW'(1);
    end else if (bins_e > EW'(MAX_BINS)) begin
      nb = EW'(MAX_BINS);
    end else begin
      nb = bins_e;
    end
    nb_m1   = nb - EW'(1);
    last_e  = EW'(in_data.last_bin);
    last_c  = (last_e > nb_m1) ? nb_m1 : last_e;
    q_empty = EW'(in_data.first_bin) > last_c;
  end

  // sample fold
  always_comb begin
    v        = in_data.sample_value;
    spb_eff  = (samples_per_bin == '0) ? pemm_pkg::SPB_BITS'(1) : samples_per_bin;
    over_end = EW'(next_bin) >= nb;
    sib_inc  = {1'b0, samples_in_bin} + (pemm_pkg::SPB_BITS + 1)'(1);
    bin_done = sib_inc >= {1'b0, spb_eff};
    if (samples_in_bin == '0) begin
      low_next  = v;
      high_next = v;
    end else begin
      low_next  = (v < current_low)  ? v : current_low;
      high_next = (v > current_high) ? v : current_high;
    end
    run_low_next  = (low_next < running_low)   ? low_next  : running_low;
    run_high_next = (high_next > running_high) ? high_next : running_high;
    next_bin_inc  = next_bin + CW'(1);
    wr_en = accept && (in_data.kind == pemm_pkg::KIND_SAMPLE) && !filled
            && !over_end && bin_done;
  end

  // a result word is loaded by a finished bin, an empty query or the last fold
  assign out_load = wr_en
                    || (accept && (in_data.kind == pemm_pkg::KIND_QUERY) && q_empty)
                    || (state == S_QFOLD);

  // fold the bin read last cycle; unwritten bins read as zero
  always_comb begin
    rd_low     = rd_data[2*SB-1:SB];
    rd_high    = rd_data[SB-1:0];
    f_low      = pend_written ? rd_low  : '0;
    f_high     = pend_written ? rd_high : '0;
    acc_low_f  = acc_low;
    acc_high_f = acc_high;
    if (pend) begin
      acc_low_f  = (f_low < acc_low)   ? f_low  : acc_low;
      acc_high_f = (f_high > acc_high) ? f_high : acc_high;
    end
  end

  pemm_env_ram #(
    .DEPTH (MAX_BINS),
    .AW    (AW),
    .DW    (2 * SB)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(next_bin)),
    .wdata ({low_next, high_next}),
    .raddr (k),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      samples_per_bin <= pemm_pkg::SPB_RESET;
      bins_in_use     <= pemm_pkg::NBINS_RESET;
      samples_in_bin  <= '0;
      current_low     <= '0;
      current_high    <= '0;
      next_bin        <= '0;
      running_low     <= '0;
      running_high    <= '0;
      filled          <= 1'b0;
      pend            <= 1'b0;
      pend_written    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pemm_pkg::CFG_SAMPLES_PER_BIN: begin
            samples_per_bin <= cfg_data;
          end
          pemm_pkg::CFG_BINS_IN_USE: begin
            bins_in_use <= cfg_data[pemm_pkg::NBINS_BITS-1:0];
          end
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.kind == pemm_pkg::KIND_SAMPLE) begin
              if (!filled) begin
                if (over_end) begin
                  // bin count lowered below the fill point: finish, drop word
                  filled <= 1'b1;
                end else if (bin_done) begin
                  samples_in_bin <= '0;
                  current_low    <= low_next;
                  current_high   <= high_next;
                  running_low    <= run_low_next;
                  running_high   <= run_high_next;
                  next_bin       <= next_bin_inc;
                  filled         <= EW'(next_bin_inc) >= nb;
                  out_data.result_kind      <= pemm_pkg::KIND_SAMPLE;
                  out_data.bin_number       <= pemm_pkg::BIN_BITS'(next_bin);
                  out_data.low_value        <= low_next;
                  out_data.high_value       <= high_next;
                  out_data.overall_low      <= run_low_next;
                  out_data.overall_high     <= run_high_next[SB-2:0];
                  out_data.complete         <= EW'(next_bin_inc) >= nb;
                end else begin
                  samples_in_bin <= sib_inc[pemm_pkg::SPB_BITS-1:0];
                  current_low    <= low_next;
                  current_high   <= high_next;
                end
              end
            end else begin
              // seed with the swapped running values
              acc_low  <= running_high;
              acc_high <= running_low;
              if (q_empty) begin
                out_data.result_kind  <= pemm_pkg::KIND_QUERY;
                out_data.bin_number   <= '0;
                out_data.low_value    <= running_high;
                out_data.high_value   <= running_low;
                out_data.overall_low  <= running_low;
                out_data.overall_high <= running_high[SB-2:0];
                out_data.complete     <= filled;
              end else begin
                k     <= AW'(in_data.first_bin);
                kend  <= AW'(last_c);
                state <= S_QRUN;
              end
            end
          end
        end
        S_QRUN: begin
          pend         <= 1'b1;
          pend_written <= CW'(k) < next_bin;
          acc_low      <= acc_low_f;
          acc_high     <= acc_high_f;
          if (k == kend) begin
            state <= S_QFOLD;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_QFOLD: begin
          pend                  <= 1'b0;
          out_data.result_kind  <= pemm_pkg::KIND_QUERY;
          out_data.bin_number   <= '0;
          out_data.low_value    <= acc_low_f;
          out_data.high_value   <= acc_high_f;
          out_data.overall_low  <= running_low;
          out_data.overall_high <= running_high[SB-2:0];
          out_data.complete     <= filled;
          state                 <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/peak_envelope_min_max_store_top_test.sv -----
// ---------------------------------------------------------------------------
// peak_envelope_min_max_store_top_test
// Self-checking bench for the peak envelope store. Sends sample and range
// query words under random source gaps and sink stalls, predicts every bin
// report and query answer from a local copy of the envelope state, and
// compares each result word field by field in arrival order.
// ---------------------------------------------------------------------------
module peak_envelope_min_max_store_top_test;

  localparam int SB         = pemm_pkg::SAMPLE_BITS;
  localparam int ENV_BINS   = 4096;
  localparam int SETTLE_CYC = 8;
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  pemm_pkg::in_word_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  pemm_pkg::out_word_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  pemm_pkg::cfg_idx_t            cfg_index = pemm_pkg::CFG_SAMPLES_PER_BIN;
  logic [pemm_pkg::CFG_BITS-1:0] cfg_data  = '0;

  // Envelope state as the block should hold it
  logic [pemm_pkg::SPB_BITS-1:0]   bin_len;
  logic [pemm_pkg::NBINS_BITS-1:0] bin_count;
  logic signed [SB-1:0]            env_lo [ENV_BINS];
  logic signed [SB-1:0]            env_hi [ENV_BINS];
  int unsigned                     fill_cnt;
  int unsigned                     next_bin;
  logic signed [SB-1:0]            cur_lo, cur_hi;
  logic signed [SB-1:0]            run_lo, run_hi;
  bit                              filled;

  pemm_pkg::out_word_t pending_results [$];
  int                  mismatch_count = 0;
  int                  sink_hold      = 0;
  bit                  steady_src     = 1'b0;

  peak_envelope_min_max_store_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fold one accepted word into the envelope state and queue any result it makes.
  task automatic predict_envelope(input pemm_pkg::in_word_t w);
    int unsigned          nb;
    int unsigned          top;
    logic signed [SB-1:0] lo, hi;
    pemm_pkg::out_word_t  r;
    nb = (bin_count == 0) ? 1 : ((bin_count > ENV_BINS) ? ENV_BINS : bin_count);
    r  = '0;
    if (w.kind == pemm_pkg::KIND_SAMPLE) begin
      if (filled) return;
      if (next_bin >= nb) begin
        filled = 1'b1;
        return;
      end
      if (fill_cnt == 0) begin
        cur_lo = w.sample_value;
        cur_hi = w.sample_value;
      end else begin
        if (w.sample_value < cur_lo) cur_lo = w.sample_value;
        if (w.sample_value > cur_hi) cur_hi = w.sample_value;
      end
      fill_cnt++;
      if (fill_cnt < ((bin_len == 0) ? 1 : bin_len)) return;
      fill_cnt         = 0;
      env_lo[next_bin] = cur_lo;
      env_hi[next_bin] = cur_hi;
      if (cur_lo < run_lo) run_lo = cur_lo;
      if (cur_hi > run_hi) run_hi = cur_hi;
      r.result_kind = pemm_pkg::KIND_SAMPLE;
      r.bin_number  = pemm_pkg::BIN_BITS'(next_bin);
      r.low_value   = cur_lo;
      r.high_value  = cur_hi;
      next_bin++;
      if (next_bin >= nb) filled = 1'b1;
    end else begin
      // empty range leaves the running extremes swapped
      lo  = run_hi;
      hi  = run_lo;
      top = (w.last_bin > nb - 1) ? nb - 1 : w.last_bin;
      for (int unsigned k = w.first_bin; k <= top; k++) begin
        if (env_lo[k] < lo) lo = env_lo[k];
        if (env_hi[k] > hi) hi = env_hi[k];
      end
      r.result_kind = pemm_pkg::KIND_QUERY;
      r.bin_number  = '0;
      r.low_value   = lo;
      r.high_value  = hi;
    end
    r.overall_low  = run_lo;
    r.overall_high = run_hi[SB-2:0];
    r.complete     = filled;
    pending_results.push_back(r);
  endtask

  task automatic send_word(input pemm_pkg::in_word_t w);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_envelope(w);
  endtask

  task automatic send_sample(input logic signed [SB-1:0] v);
    pemm_pkg::in_word_t w;
    w.kind         = pemm_pkg::KIND_SAMPLE;
    w.sample_value = v;
    w.first_bin    = pemm_pkg::BIN_BITS'($urandom);
    w.last_bin     = pemm_pkg::BIN_BITS'($urandom);
    send_word(w);
  endtask

  task automatic send_query(input int first, input int last);
    pemm_pkg::in_word_t w;
    w.kind         = pemm_pkg::KIND_QUERY;
    w.sample_value = SB'($urandom);
    w.first_bin    = pemm_pkg::BIN_BITS'(first);
    w.last_bin     = pemm_pkg::BIN_BITS'(last);
    send_word(w);
  endtask

  // Drop valid, wait out every expected result, then let a partial bin settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input pemm_pkg::cfg_idx_t idx,
                           input logic [pemm_pkg::CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == pemm_pkg::CFG_SAMPLES_PER_BIN) bin_len = value;
    else bin_count = value[pemm_pkg::NBINS_BITS-1:0];
    @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_query(0, 0);
    send_query(12, 3);
    send_query(4095, 4095);
    send_query(4000, 4095);
    send_query(0, 4095);
  endtask

  task automatic test_single_sample_bins();
    send_sample(7);
    send_sample(-7);
    send_sample(300);
    send_sample(-300);
    send_query(0, 3);
    send_query(1, 2);
  endtask

  task automatic test_zero_bin_length();
    wait_idle();
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'd0);
    send_sample(5);
    send_sample(-5);
    send_query(0, next_bin + 4);
  endtask

  task automatic test_bin_length_lowered();
    wait_idle();
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'hFFFF);
    repeat (6) send_sample($signed(SB'($urandom)) >>> 12);
    send_query(0, next_bin);
    wait_idle();
    // count already past the new length: next sample closes the bin
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'd3);
    send_sample(-1000);
    repeat (3) send_sample($signed(SB'($urandom)) >>> 12);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'd1);
    sink_hold = 400;
    while (sink_hold != 0) @(posedge clk);
    steady_src = 1'b1;
    repeat (48) send_sample($signed(SB'($urandom)) >>> 10);
    steady_src = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int                              roll, first, last, shift;
    logic [pemm_pkg::SPB_BITS-1:0]   spb;
    logic signed [SB-1:0]            v;
    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      case (seg)
        3:       spb = 16'd0;
        4:       spb = pemm_pkg::SPB_BITS'($urandom_range(3, 12));
        5:       spb = 16'd5;
        6:       spb = pemm_pkg::SPB_BITS'($urandom_range(1, 4));
        default: spb = (seg % 2 == 0) ? 16'd1 : 16'd2;
      endcase
      write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, spb);
      if (seg % 3 == 1)
        write_reg(pemm_pkg::CFG_BINS_IN_USE, 16'(4096 + $urandom_range(0, 4095)));
      steady_src = (seg == 2);
      // widen the sample range per segment so the running extremes keep moving
      shift = 14 - 2 * seg;
      for (int n = 0; n < 175; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) begin
            first = $urandom_range(0, next_bin);
            last  = first + $urandom_range(0, 15);
          end else if (roll < 70) begin
            first = $urandom_range(0, 4095);
            last  = first + $urandom_range(0, 7);
          end else if (roll < 95) begin
            first = $urandom_range(1, 4095);
            last  = $urandom_range(0, first - 1);
          end else begin
            first = 0;
            last  = 4095;
          end
          if (last > 4095) last = 4095;
          send_query(first, last);
        end else begin
          v = $signed(SB'($urandom)) >>> shift;
          if (seg == 7 && roll > 94) v = (roll[0]) ? S_MAX : S_MIN;
          send_sample(v);
        end
      end
    end
    steady_src = 1'b0;
  endtask

  task automatic test_sample_extremes();
    wait_idle();
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'd1);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(-1);
    send_sample(0);
    wait_idle();
    write_reg(pemm_pkg::CFG_SAMPLES_PER_BIN, 16'd2);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_query(next_bin - 6, next_bin - 1);
  endtask

  task automatic test_completion();
    wait_idle();
    // data bits above the register width drop: the register reads zero (one bin)
    write_reg(pemm_pkg::CFG_BINS_IN_USE, 16'h2000);
    send_sample(1234);
    repeat (3) send_sample(SB'($urandom));
    send_query(0, 4095);
    send_query(1, 4095);
    wait_idle();
    write_reg(pemm_pkg::CFG_BINS_IN_USE, 16'd1);
    send_query(0, 0);
    send_sample(-77);
    wait_idle();
    write_reg(pemm_pkg::CFG_BINS_IN_USE, 16'd37);
    send_query(30, 4095);
    send_query(0, 4095);
    wait_idle();
    write_reg(pemm_pkg::CFG_BINS_IN_USE, 16'hFFFF);
    send_query(4090, 4095);
    send_sample(S_MIN);
    wait_idle();
    write_reg(pemm_pkg::CFG_BINS_IN_USE, pemm_pkg::NBINS_RESET);
    send_query(next_bin - 3, next_bin + 2);
  endtask

  initial begin : result_sink
    int span;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        span      = sink_hold;
        sink_hold = 0;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 5) begin
        span      = $urandom_range(100, 300);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 60) begin
        span      = $urandom_range(1, 20);
        out_ready <= 1'b1;
      end else begin
        span      = 1 + pick_gap();
        out_ready <= 1'b0;
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    pemm_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word expected none got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (out_data.result_kind !== want.result_kind)
            $display("%0t: result_kind expected %0d got %0d", $time,
                     want.result_kind, out_data.result_kind);
          if (out_data.bin_number !== want.bin_number)
            $display("%0t: bin_number expected %0d got %0d", $time,
                     want.bin_number, out_data.bin_number);
          if (out_data.low_value !== want.low_value)
            $display("%0t: low_value expected %0d got %0d", $time,
                     want.low_value, out_data.low_value);
          if (out_data.high_value !== want.high_value)
            $display("%0t: high_value expected %0d got %0d", $time,
                     want.high_value, out_data.high_value);
          if (out_data.overall_low !== want.overall_low)
            $display("%0t: overall_low expected %0d got %0d", $time,
                     want.overall_low, out_data.overall_low);
          if (out_data.overall_high !== want.overall_high)
            $display("%0t: overall_high expected %0d got %0d", $time,
                     want.overall_high, out_data.overall_high);
          if (out_data.complete !== want.complete)
            $display("%0t: complete expected %0d got %0d", $time,
                     want.complete, out_data.complete);
        end
      end
    end
  end

  initial begin
    #18000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    bin_len   = pemm_pkg::SPB_RESET;
    bin_count = pemm_pkg::NBINS_RESET;
    fill_cnt  = 0;
    next_bin  = 0;
    cur_lo    = '0;
    cur_hi    = '0;
    run_lo    = '0;
    run_hi    = '0;
    filled    = 1'b0;
    foreach (env_lo[i]) begin
      env_lo[i] = '0;
      env_hi[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_single_sample_bins();
    test_zero_bin_length();
    test_bin_length_lowered();
    test_backpressure();
    test_random_traffic();
    test_sample_extremes();
    test_completion();
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
